// ===== hw/rtl/hld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hld_pkg
// Shared types, beat layouts and saturation helpers for the luma deblocking
// line filter.
// ----------------------------------------------------------------------------
package hld_pkg;

  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned SIDE_W      = 4 * SAMPLE_W;
  localparam int unsigned TC_W        = 5;
  localparam int unsigned ITEM_W      = 2 * SIDE_W + 3 + TC_W + 2;
  localparam int unsigned IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = 2 * SIDE_W;

  // Input beat, lowest field in the lowest bits of the packed struct.
  typedef struct packed {
    logic              filter_q;
    logic              filter_p;
    logic [TC_W-1:0]   tc;
    logic              adjust_q1;
    logic              adjust_p1;
    logic              strong_mode;
    logic [SIDE_W-1:0] q_side;
    logic [SIDE_W-1:0] p_side;
  } hld_item_t;

  typedef struct packed {
    logic [SIDE_W-1:0] q_side_out;
    logic [SIDE_W-1:0] p_side_out;
  } hld_result_t;

  // Saturate a signed value to the 8-bit sample range.
  function automatic logic [7:0] sat8(input logic signed [9:0] v);
    logic [7:0] r;
    if (v < 10'sd0) begin
      r = 8'd0;
    end else if (v > 10'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // Limit a strong-filter average to within t2 of the original sample.
  function automatic logic [7:0] clip_near(input logic [7:0] v, input logic [7:0] org,
                                           input logic [5:0] t2);
    logic signed [9:0] lo;
    logic signed [9:0] hi;
    logic signed [9:0] vs;
    logic signed [9:0] r;
    lo = $signed({2'b00, org}) - $signed({4'b0000, t2});
    hi = $signed({2'b00, org}) + $signed({4'b0000, t2});
    vs = $signed({2'b00, v});
    if (vs < lo) begin
      r = lo;
    end else if (vs > hi) begin
      r = hi;
    end else begin
      r = vs;
    end
    return sat8(r);
  endfunction

endpackage

// ===== hw/rtl/hld_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hld_filter
// Combinational strong and weak luma filter for one line of eight samples.
// ----------------------------------------------------------------------------
module hld_filter
  import hld_pkg::*;
(
  input  hld_item_t   item,
  output hld_result_t result
);

  logic [7:0] p0, p1, p2, p3, q0, q1, q2, q3;
  logic [5:0] t2;

  // Strong filter averages.
  logic [10:0] sa0, sa2, sb0, sb2;
  logic [9:0]  sa1, sb1;
  logic [7:0]  sp0, sp1, sp2, sq0, sq1, sq2;

  // Weak filter.
  logic signed [12:0] dq0p0, dq1p1, dsum;
  logic signed [8:0]  d0;
  logic [7:0]         ad;
  logic [8:0]         tc10;
  logic               weak_on;
  logic signed [5:0]  tcs;
  logic signed [5:0]  d;
  logic signed [4:0]  ht;
  logic [8:0]         avg_p_w, avg_q_w;
  logic signed [9:0]  dps, dqs;
  logic signed [8:0]  dp, dq;
  logic signed [8:0]  dpc, dqc;
  logic [7:0]         wp0, wp1, wq0, wq1;

  assign {p3, p2, p1, p0} = item.p_side;
  assign {q3, q2, q1, q0} = item.q_side;
  assign t2 = {item.tc, 1'b0};

  always_comb begin
    sa0 = 11'(p2) + (11'(p1) << 1) + (11'(p0) << 1) + (11'(q0) << 1) + 11'(q1) + 11'd4;
    sa1 = 10'(p2) + 10'(p1) + 10'(p0) + 10'(q0) + 10'd2;
    sa2 = (11'(p3) << 1) + (11'(p2) << 1) + 11'(p2) + 11'(p1) + 11'(p0) + 11'(q0)
          + 11'd4;
    sb0 = 11'(p1) + (11'(p0) << 1) + (11'(q0) << 1) + (11'(q1) << 1) + 11'(q2) + 11'd4;
    sb1 = 10'(p0) + 10'(q0) + 10'(q1) + 10'(q2) + 10'd2;
    sb2 = 11'(p0) + 11'(q0) + 11'(q1) + (11'(q2) << 1) + 11'(q2) + (11'(q3) << 1)
          + 11'd4;
    sp0 = clip_near(sa0[10:3], p0, t2);
    sp1 = clip_near(sa1[9:2], p1, t2);
    sp2 = clip_near(sa2[10:3], p2, t2);
    sq0 = clip_near(sb0[10:3], q0, t2);
    sq1 = clip_near(sb1[9:2], q1, t2);
    sq2 = clip_near(sb2[10:3], q2, t2);
  end

  always_comb begin
    dq0p0 = $signed({5'b0, q0}) - $signed({5'b0, p0});
    dq1p1 = $signed({5'b0, q1}) - $signed({5'b0, p1});
    dsum  = (dq0p0 <<< 3) + dq0p0 - ((dq1p1 <<< 1) + dq1p1) + 13'sd8;
    d0    = dsum[12:4];
    ad    = d0[8] ? 8'(-d0) : d0[7:0];
    tc10  = (9'(item.tc) << 3) + (9'(item.tc) << 1);
    weak_on = {1'b0, ad} < tc10;

    tcs = $signed({1'b0, item.tc});
    if (d0 > 9'(tcs)) begin
      d = tcs;
    end else if (d0 < -9'(tcs)) begin
      d = -tcs;
    end else begin
      d = d0[5:0];
    end
    ht = $signed({1'b0, item.tc[TC_W-1:1]});

    wp0 = sat8($signed({2'b00, p0}) + 10'(d));
    wq0 = sat8($signed({2'b00, q0}) - 10'(d));

    avg_p_w = 9'(p2) + 9'(p0) + 9'd1;
    avg_q_w = 9'(q2) + 9'd1 + 9'(q0);
    dps = $signed({2'b00, avg_p_w[8:1]}) - $signed({2'b00, p1}) + 10'(d);
    dqs = $signed({2'b00, avg_q_w[8:1]}) - $signed({2'b00, q1}) - 10'(d);
    dp  = dps[9:1];
    dq  = dqs[9:1];
    if (dp > 9'(ht)) begin
      dpc = 9'(ht);
    end else if (dp < -9'(ht)) begin
      dpc = -9'(ht);
    end else begin
      dpc = dp;
    end
    if (dq > 9'(ht)) begin
      dqc = 9'(ht);
    end else if (dq < -9'(ht)) begin
      dqc = -9'(ht);
    end else begin
      dqc = dq;
    end
    wp1 = sat8($signed({2'b00, p1}) + 10'(dpc));
    wq1 = sat8($signed({2'b00, q1}) + 10'(dqc));
  end

  always_comb begin
    result.p_side_out = item.p_side;
    result.q_side_out = item.q_side;
    if (item.strong_mode) begin
      if (item.filter_p) begin
        result.p_side_out = {p3, sp2, sp1, sp0};
      end
      if (item.filter_q) begin
        result.q_side_out = {q3, sq2, sq1, sq0};
      end
    end else if (weak_on) begin
      if (item.filter_p) begin
        result.p_side_out = {p3, p2, (item.adjust_p1 ? wp1 : p1), wp0};
      end
      if (item.filter_q) begin
        result.q_side_out = {q3, q2, (item.adjust_q1 ? wq1 : q1), wq0};
      end
    end
  end

endmodule

// ===== hw/rtl/hevc_luma_deblock_line.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hevc_luma_deblock_line
// H.265 luma deblocking filter for one line of eight 8-bit samples.
// ----------------------------------------------------------------------------
// Each beat on the slave stream carries one line across a block edge,
// p3..p0 and q0..q3, with the filter mode, the tc threshold and the per-side
// enables. Each beat on the master stream carries the filtered line, with
// p3 and q3 always unchanged.
// The block is a two-register pipeline: the incoming beat is captured in an
// input register, the strong and weak filters are evaluated in one pass of
// combinational logic, and the result is held in an output register.
// A beat accepted into the input register moves on to the output register,
// which offers it on the master stream. A new beat can be accepted every
// cycle while the receiver keeps taking results, so the sustained rate is
// one line per cycle, set by the single filter pass between the registers.
// When the receiver stalls, the output register holds its beat and the
// input register can still take one more beat; only when both are full is
// s_axis_tready lowered. Reset empties both registers; no result is lost
// or repeated across a stall.
// ----------------------------------------------------------------------------
module hevc_luma_deblock_line
  import hld_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0 up: p_side[31:0], q_side[63:32], strong_mode[64],
  // adjust_p1[65], adjust_q1[66], tc[71:67], filter_p[72], filter_q[73];
  // bits 79:74 are zero.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0 up: p_side_out[31:0], q_side_out[63:32].
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Input register.
  logic        in_valid;
  hld_item_t   in_item;
  // Output register.
  logic        out_valid;
  hld_result_t out_data;

  hld_result_t filt_result;
  logic        in_ready;
  logic        out_ready;

  // The output register may load whenever it is empty or being drained, and
  // the input register may load whenever it is empty or moving on.
  assign out_ready = !out_valid || m_axis_tready;
  assign in_ready  = !in_valid || out_ready;

  hld_filter u_filter (
    .item   (in_item),
    .result (filt_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  // Payload registers carry no reset; they are qualified by the valid flags.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && in_ready) begin
      in_item <= hld_item_t'(s_axis_tdata[ITEM_W-1:0]);
    end
    if (in_valid && out_ready) begin
      out_data <= filt_result;
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// ===== hw/rtl/hld_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hld_checker
// Port-level checks on the luma deblocking line filter, bound to the top.
// ----------------------------------------------------------------------------
module hld_checker
  import hld_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // A stalled result beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  // An empty output side never refuses input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input refused while output empty");

  // With the receiver ready while a beat sits in the input register, it is offered.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_fire ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after two cycles");

  // With both sides disabled the line passes through unchanged.
  a_bypass: assert property (@(posedge clk) disable iff (rst)
    s_fire && !s_axis_tdata[2*SIDE_W+3+TC_W] && !s_axis_tdata[2*SIDE_W+3+TC_W+1]
    ##1 m_axis_tready |=> m_axis_tdata == $past(s_axis_tdata[OUT_TDATA_W-1:0], 2))
    else $error("disabled line was modified");

  // The outermost samples p3 and q3 are never modified.
  a_outer_kept: assert property (@(posedge clk) disable iff (rst)
    s_fire ##1 m_axis_tready |=>
      m_axis_tdata[SIDE_W-1:SIDE_W-8] == $past(s_axis_tdata[SIDE_W-1:SIDE_W-8], 2) &&
      m_axis_tdata[2*SIDE_W-1:2*SIDE_W-8] == $past(s_axis_tdata[2*SIDE_W-1:2*SIDE_W-8], 2))
    else $error("outer sample modified");

endmodule

bind hevc_luma_deblock_line hld_checker u_hld_checker (.*);

// ===== sim/hld_line_sb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hld_line_sb_pkg
// Scoreboard for the luma deblocking line filter. It predicts the filtered
// line for every accepted input beat and checks result beats in order.
// ----------------------------------------------------------------------------
package hld_line_sb_pkg;

  import hld_pkg::*;

  class deblock_scoreboard;

    hld_result_t filtered_lines[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function int clip3(int v, int lo, int hi);
      if (v < lo) begin
        return lo;
      end
      if (v > hi) begin
        return hi;
      end
      return v;
    endfunction

    // Luma deblocking of one line: p3..p0 | q0..q3.
    function hld_result_t deblock_line(hld_item_t line);
      int p[4];
      int q[4];
      int np[4];
      int nq[4];
      int a[3];
      int b[3];
      int tcv;
      int t2;
      int d0;
      int ad;
      int d;
      int ht;
      int dp;
      int dq;
      hld_result_t r;
      tcv = int'(line.tc);
      for (int k = 0; k < 4; k++) begin
        p[k]  = int'(line.p_side[8*k +: 8]);
        q[k]  = int'(line.q_side[8*k +: 8]);
        np[k] = p[k];
        nq[k] = q[k];
      end
      if (line.strong_mode) begin
        t2   = 2 * tcv;
        a[0] = (p[2] + 2*p[1] + 2*p[0] + 2*q[0] + q[1] + 4) >>> 3;
        a[1] = (p[2] + p[1] + p[0] + q[0] + 2) >>> 2;
        a[2] = (2*p[3] + 3*p[2] + p[1] + p[0] + q[0] + 4) >>> 3;
        b[0] = (p[1] + 2*p[0] + 2*q[0] + 2*q[1] + q[2] + 4) >>> 3;
        b[1] = (p[0] + q[0] + q[1] + q[2] + 2) >>> 2;
        b[2] = (p[0] + q[0] + q[1] + 3*q[2] + 2*q[3] + 4) >>> 3;
        for (int k = 0; k < 3; k++) begin
          if (line.filter_p) begin
            np[k] = clip3(a[k], p[k] - t2, p[k] + t2);
          end
          if (line.filter_q) begin
            nq[k] = clip3(b[k], q[k] - t2, q[k] + t2);
          end
        end
      end else begin
        d0 = (9 * (q[0] - p[0]) - 3 * (q[1] - p[1]) + 8) >>> 4;
        ad = (d0 < 0) ? -d0 : d0;
        if (ad < tcv * 10) begin
          d  = clip3(d0, -tcv, tcv);
          ht = tcv >>> 1;
          if (line.filter_p) begin
            np[0] = clip3(p[0] + d, 0, 255);
            if (line.adjust_p1) begin
              dp    = ((((p[2] + p[0] + 1) >>> 1) - p[1] + d) >>> 1);
              np[1] = clip3(p[1] + clip3(dp, -ht, ht), 0, 255);
            end
          end
          if (line.filter_q) begin
            nq[0] = clip3(q[0] - d, 0, 255);
            if (line.adjust_q1) begin
              dq    = ((((q[2] + q[0] + 1) >>> 1) - q[1] - d) >>> 1);
              nq[1] = clip3(q[1] + clip3(dq, -ht, ht), 0, 255);
            end
          end
        end
      end
      for (int k = 0; k < 4; k++) begin
        r.p_side_out[8*k +: 8] = 8'(clip3(np[k], 0, 255));
        r.q_side_out[8*k +: 8] = 8'(clip3(nq[k], 0, 255));
      end
      return r;
    endfunction

    function void note_line(hld_item_t line);
      filtered_lines.push_back(deblock_line(line));
    endfunction

    function void check_line(hld_result_t got);
      hld_result_t want;
      if (filtered_lines.size() == 0) begin
        $error("result beat with no line pending: p_side_out %h, q_side_out %h",
               got.p_side_out, got.q_side_out);
        errors++;
        return;
      end
      want = filtered_lines.pop_front();
      if (got.p_side_out !== want.p_side_out) begin
        $error("p_side_out: expected %h, actual %h", want.p_side_out, got.p_side_out);
        errors++;
      end
      if (got.q_side_out !== want.q_side_out) begin
        $error("q_side_out: expected %h, actual %h", want.q_side_out, got.q_side_out);
        errors++;
      end
    endfunction

    function int pending();
      return filtered_lines.size();
    endfunction

  endclass

endpackage

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the luma deblocking line filter.
// ----------------------------------------------------------------------------
// A short directed sequence covers the sample extremes, both filter modes,
// disabled sides, a weak delta that is too large, a zero tc and the adjust
// flags in strong mode. Random lines follow, mostly smooth lines with a step
// across the edge so that the weak filter actually acts, mixed with fully
// random noise. The run passes through four flow-control phases, and every
// result beat is compared with the scoreboard's prediction in order.
// ----------------------------------------------------------------------------
module tb_top;

  import hld_pkg::*;
  import hld_line_sb_pkg::*;

  localparam int unsigned LINES_PER_PHASE = 175;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned DRAIN_CYCLES    = 8;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // Fields from bit 0 up: p_side, q_side, strong_mode, adjust_p1, adjust_q1,
  // tc, filter_p, filter_q; the top six bits are zero.
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // Fields from bit 0 up: p_side_out, q_side_out.
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Percentages for idling on the slave side and stalling on the master side.
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned cycle_count = 0;

  deblock_scoreboard deblock_sb;

  hevc_luma_deblock_line uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  // Free-running cycle count; the watchdog below ends a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // The receiver decides at every falling edge whether it stalls in the
  // following cycle, so stalls land on every phase of the pipeline.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Result beats are sampled at the rising edge, before the block's own
  // registers update, and checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      deblock_sb.check_line(m_axis_tdata);
    end
  end

  function automatic hld_item_t make_line(logic [31:0] p, logic [31:0] q, logic strong_sel,
                                          logic adj_p, logic adj_q, logic [4:0] tc,
                                          logic en_p, logic en_q);
    hld_item_t line;
    line.p_side      = p;
    line.q_side      = q;
    line.strong_mode = strong_sel;
    line.adjust_p1   = adj_p;
    line.adjust_q1   = adj_q;
    line.tc          = tc;
    line.filter_p    = en_p;
    line.filter_q    = en_q;
    return line;
  endfunction

  // A sample scattered around a centre value and saturated to 8 bits.
  function automatic logic [7:0] sample_near(int centre, int spread);
    int v;
    v = centre + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) begin
      v = 0;
    end else if (v > 255) begin
      v = 255;
    end
    return 8'(v);
  endfunction

  // Three lines in four are smooth with a modest step across the edge, which
  // is what lets the weak filter pass its delta test; the rest are noise.
  function automatic hld_item_t random_line();
    hld_item_t line;
    int base;
    int step;
    int spread;
    line = hld_item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
    if ($urandom_range(99) < 75) begin
      base   = int'($urandom_range(255));
      step   = int'($urandom_range(48)) - 24;
      spread = int'($urandom_range(1, 12));
      for (int k = 0; k < 4; k++) begin
        line.p_side[8*k +: 8] = sample_near(base, spread);
        line.q_side[8*k +: 8] = sample_near(base + step, spread);
      end
    end
    return line;
  endfunction

  // Offers one line on the slave stream and returns at the falling edge
  // after the beat has been accepted. tvalid stays high into the next call
  // unless that call starts with an idle cycle.
  task automatic send_line(input hld_item_t line);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - ITEM_W){1'b0}}, line};
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    deblock_sb.note_line(line);
    @(negedge clk);
  endtask

  task automatic send_directed_lines();
    // Extremes of the samples, weak with zero tc and strong with the largest.
    send_line(make_line(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 5'd0, 1'b1, 1'b1));
    send_line(make_line(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 5'd31, 1'b1, 1'b1));
    send_line(make_line(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 5'd31, 1'b1, 1'b1));
    // Strong filter over a step, then with tc zero, which must change nothing.
    send_line(make_line(32'h1010_1010, 32'h8080_8080, 1'b1, 1'b0, 1'b0, 5'd31, 1'b1, 1'b1));
    send_line(make_line(32'h1010_1010, 32'h8080_8080, 1'b1, 1'b0, 1'b0, 5'd0, 1'b1, 1'b1));
    // Strong filter with one or both sides disabled, adjust flags ignored.
    send_line(make_line(32'h2030_4050, 32'h6070_8090, 1'b1, 1'b1, 1'b0, 5'd9, 1'b0, 1'b1));
    send_line(make_line(32'h2030_4050, 32'h6070_8090, 1'b1, 1'b0, 1'b1, 5'd9, 1'b1, 1'b0));
    send_line(make_line(32'h2030_4050, 32'h6070_8090, 1'b1, 1'b1, 1'b1, 5'd9, 1'b0, 1'b0));
    // Weak filter on a small step, with every combination of the adjust flags.
    send_line(make_line(32'h4040_4040, 32'h4444_4444, 1'b0, 1'b1, 1'b1, 5'd10, 1'b1, 1'b1));
    send_line(make_line(32'h4042_3F40, 32'h4546_4344, 1'b0, 1'b1, 1'b0, 5'd4, 1'b1, 1'b1));
    send_line(make_line(32'h4042_3F40, 32'h4546_4344, 1'b0, 1'b0, 1'b1, 5'd4, 1'b1, 1'b1));
    send_line(make_line(32'h4042_3F40, 32'h4546_4344, 1'b0, 1'b0, 1'b0, 5'd4, 1'b1, 1'b1));
    // Weak filter with one side disabled, including its p1 or q1 correction.
    send_line(make_line(32'h4042_3F40, 32'h4546_4344, 1'b0, 1'b1, 1'b1, 5'd4, 1'b0, 1'b1));
    send_line(make_line(32'h4042_3F40, 32'h4546_4344, 1'b0, 1'b1, 1'b1, 5'd4, 1'b1, 1'b0));
    // Weak delta too large for the threshold, and the small step again with tc zero.
    send_line(make_line(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 5'd1, 1'b1, 1'b1));
    send_line(make_line(32'h4040_4040, 32'h4444_4444, 1'b0, 1'b1, 1'b1, 5'd0, 1'b1, 1'b1));
    // Negative delta, alternating bit patterns and lines near full scale and zero.
    send_line(make_line(32'h6060_6060, 32'h5858_5858, 1'b0, 1'b1, 1'b1, 5'd31, 1'b1, 1'b1));
    send_line(make_line(32'h55AA_55AA, 32'hAA55_AA55, 1'b0, 1'b1, 1'b1, 5'd31, 1'b1, 1'b1));
    send_line(make_line(32'h55AA_55AA, 32'hAA55_AA55, 1'b1, 1'b0, 1'b0, 5'd31, 1'b1, 1'b1));
    send_line(make_line(32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0, 1'b1, 1'b1, 5'd31, 1'b1, 1'b1));
    send_line(make_line(32'h0000_000F, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 5'd31, 1'b1, 1'b1));
  endtask

  initial begin
    deblock_sb     = new();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;

    // Synchronous reset held high on rising edges, then released on a falling one.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Phase one runs without any idling and also carries the directed lines.
    send_directed_lines();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 78;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 78;
        end
        default: begin
          src_idle_pct   = 31;
          sink_stall_pct = 31;
        end
      endcase
      for (int n = 0; n < LINES_PER_PHASE; n++) begin
        send_line(random_line());
      end
    end
    s_axis_tvalid <= 1'b0;

    // Let the pipeline drain; the watchdog catches a result that never comes.
    while (deblock_sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (deblock_sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== hevc_luma_deblock_line.f =====
hw/rtl/hld_pkg.sv
hw/rtl/hld_filter.sv
hw/rtl/hevc_luma_deblock_line.sv
hw/rtl/hld_checker.sv
sim/hld_line_sb_pkg.sv
sim/tb_top.sv
